/* rtl/hck_pkg.sv */
// Shared types and constants for the hue chroma key compositor.
// No dependencies.
package hck_pkg;

	localparam int COLOR_BITS = 8;
	localparam int IDX_W      = 2;
	localparam int DIFF_W     = COLOR_BITS + 1;
	localparam int N_W        = COLOR_BITS + 3;
	localparam int NUM_W      = 17;
	localparam int DV_W       = COLOR_BITS + 1;
	localparam int Q_W        = 8;
	localparam int BAND_W     = COLOR_BITS + 2;

	localparam logic [IDX_W-1:0]  REG_KEY_HUE   = 2'd0;
	localparam logic [IDX_W-1:0]  REG_KEY_WIDTH = 2'd1;

	localparam logic [COLOR_BITS-1:0] KEY_HUE_RST   = 8'd60;
	localparam logic [COLOR_BITS-1:0] KEY_WIDTH_RST = 8'd10;
	localparam logic [Q_W-1:0]        HUE_WRAP      = 8'd180;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	typedef struct packed {
		logic [COLOR_BITS-1:0] fb;
		logic [COLOR_BITS-1:0] fg;
		logic [COLOR_BITS-1:0] fr;
		logic [COLOR_BITS-1:0] bb;
		logic [COLOR_BITS-1:0] bg;
		logic [COLOR_BITS-1:0] br;
	} pix_t;

endpackage

/* rtl/hue_chroma_key_compositor_core.sv */
// Hue-range chroma key compositor: BGR foreground hue test, picks background in band.
// Depends on hck_pkg.
// The start transfer reaches the done strobe through stages 1 to 3, the divider stages and the compare stage.
// Throughput: one pixel per clock; busy is always low, set by the 12-stage pipeline
// (3 hue stages, 8 restoring divider stages of one quotient bit each, 1 compare stage).
// Reset clears all valid bits and loads key_hue = 60, key_width = 10.
// The receiver cannot stall; each result shows for exactly one cycle.
module hue_chroma_key_compositor_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          wr_en,
	input  logic [hck_pkg::IDX_W-1:0]     wr_index,
	input  logic [hck_pkg::COLOR_BITS-1:0] wr_data,
	input  logic [hck_pkg::COLOR_BITS-1:0] fg_blue,
	input  logic [hck_pkg::COLOR_BITS-1:0] fg_green,
	input  logic [hck_pkg::COLOR_BITS-1:0] fg_red,
	input  logic [hck_pkg::COLOR_BITS-1:0] bg_blue,
	input  logic [hck_pkg::COLOR_BITS-1:0] bg_green,
	input  logic [hck_pkg::COLOR_BITS-1:0] bg_red,
	output logic                          done,
	output logic [hck_pkg::COLOR_BITS-1:0] out_blue,
	output logic [hck_pkg::COLOR_BITS-1:0] out_green,
	output logic [hck_pkg::COLOR_BITS-1:0] out_red,
	output logic                          keyed
);
	import hck_pkg::*;

	localparam int DIV_STEPS = Q_W;

	logic [COLOR_BITS-1:0] key_hue_q;
	logic [COLOR_BITS-1:0] key_width_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hue_q   <= KEY_HUE_RST;
			key_width_q <= KEY_WIDTH_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_KEY_HUE:   key_hue_q   <= wr_data;
				REG_KEY_WIDTH: key_width_q <= wr_data;
				default: ;
			endcase
		end
	end

	// stage 1: max/min, spread, sector and raw difference
	logic                    in_xfer;
	logic                    r_max, g_max;
	logic [COLOR_BITS-1:0]   mx, mn;
	sector_t                 sec;
	logic signed [DIFF_W-1:0] diff;

	assign in_xfer = start & ~busy;

	always_comb begin
		r_max = (fg_red >= fg_green) && (fg_red >= fg_blue);
		g_max = !r_max && (fg_green >= fg_blue);
		if (r_max) begin
			mx   = fg_red;
			sec  = SEC_RED;
			diff = $signed({1'b0, fg_green}) - $signed({1'b0, fg_blue});
		end else if (g_max) begin
			mx   = fg_green;
			sec  = SEC_GREEN;
			diff = $signed({1'b0, fg_blue}) - $signed({1'b0, fg_red});
		end else begin
			mx   = fg_blue;
			sec  = SEC_BLUE;
			diff = $signed({1'b0, fg_red}) - $signed({1'b0, fg_green});
		end
		mn = fg_red;
		if (fg_green < mn) mn = fg_green;
		if (fg_blue < mn)  mn = fg_blue;
	end

	logic                     v_s1;
	pix_t                     pix_s1;
	logic [COLOR_BITS-1:0]    d_s1;
	sector_t                  sec_s1;
	logic signed [DIFF_W-1:0] diff_s1;

	// stage 2: hue numerator n in [0, 6d)
	logic [N_W-1:0]        off;
	logic [N_W-1:0]        six_d;
	logic signed [N_W:0]   nsum;
	logic [N_W-1:0]        n_val;

	always_comb begin
		case (sec_s1)
			SEC_RED:   off = '0;
			SEC_GREEN: off = {2'b00, d_s1, 1'b0};
			SEC_BLUE:  off = {1'b0, d_s1, 2'b00};
			default:   off = '0;
		endcase
		six_d = {1'b0, d_s1, 2'b00} + {2'b00, d_s1, 1'b0};
		nsum  = $signed((N_W+1)'(diff_s1)) + $signed({1'b0, off});
		if (nsum < 0)
			n_val = N_W'(nsum + $signed({1'b0, six_d}));
		else
			n_val = N_W'(nsum);
	end

	logic                  v_s2;
	pix_t                  pix_s2;
	logic [COLOR_BITS-1:0] d_s2;
	logic [N_W-1:0]        n_s2;

	// stage 3: numerator 60n + d, divisor 2d
	logic [NUM_W-1:0] num;
	assign num = (NUM_W'(n_s2) << 6) - (NUM_W'(n_s2) << 2) + NUM_W'(d_s2);

	logic             v_s3;
	pix_t             pix_s3;
	logic             grey_s3;
	logic [NUM_W-1:0] rem_s3;
	logic [DV_W-1:0]  dv_s3;

	// stages 4..11: restoring divider, one quotient bit per stage
	logic             dv_v   [0:DIV_STEPS];
	pix_t             dv_pix [0:DIV_STEPS];
	logic             dv_grey[0:DIV_STEPS];
	logic [NUM_W-1:0] dv_rem [0:DIV_STEPS];
	logic [DV_W-1:0]  dv_den [0:DIV_STEPS];
	logic [Q_W-1:0]   dv_quo [0:DIV_STEPS];

	assign dv_v[0]    = v_s3;
	assign dv_pix[0]  = pix_s3;
	assign dv_grey[0] = grey_s3;
	assign dv_rem[0]  = rem_s3;
	assign dv_den[0]  = dv_s3;
	assign dv_quo[0]  = '0;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [NUM_W-1:0] dsh;
		logic             ge;
		assign dsh = NUM_W'(dv_den[j]) << (DIV_STEPS - 1 - j);
		assign ge  = dv_rem[j] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			dv_pix[j+1]  <= dv_pix[j];
			dv_grey[j+1] <= dv_grey[j];
			dv_den[j+1]  <= dv_den[j];
			dv_rem[j+1]  <= ge ? dv_rem[j] - dsh : dv_rem[j];
			dv_quo[j+1]  <= {dv_quo[j][Q_W-2:0], ge};
		end
	end

	// stage 12: band compare and select
	logic [Q_W-1:0]           hue;
	logic signed [BAND_W-1:0] band_lo, band_hi, hue_sx;
	logic                     in_band;
	pix_t                     pf;

	assign pf      = dv_pix[DIV_STEPS];
	assign hue     = (dv_grey[DIV_STEPS] || dv_quo[DIV_STEPS] >= HUE_WRAP) ?
	                 '0 : dv_quo[DIV_STEPS];
	assign hue_sx  = $signed({2'b00, hue});
	assign band_lo = $signed({2'b00, key_hue_q}) - $signed({2'b00, key_width_q});
	assign band_hi = $signed({2'b00, key_hue_q}) + $signed({2'b00, key_width_q});
	assign in_band = (hue_sx >= band_lo) && (hue_sx <= band_hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= in_xfer;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			done <= dv_v[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		pix_s1  <= '{fb: fg_blue, fg: fg_green, fr: fg_red,
		             bb: bg_blue, bg: bg_green, br: bg_red};
		d_s1    <= mx - mn;
		sec_s1  <= sec;
		diff_s1 <= diff;

		pix_s2 <= pix_s1;
		d_s2   <= d_s1;
		n_s2   <= n_val;

		pix_s3  <= pix_s2;
		grey_s3 <= (d_s2 == '0);
		rem_s3  <= num;
		dv_s3   <= {d_s2, 1'b0};

		out_blue  <= in_band ? pf.bb : pf.fb;
		out_green <= in_band ? pf.bg : pf.fg;
		out_red   <= in_band ? pf.br : pf.fr;
		keyed     <= in_band;
	end

endmodule
